[rtl/core/dec64_pkg.sv]
package dec64_pkg;

	localparam int COEF_BITS = 52;
	localparam int EXP_BITS  = 11;
	localparam logic [63:0] COEF_MAX = (64'd1 << COEF_BITS) - 64'd1;
	localparam logic [63:0] SIGN_BIT = 64'h8000 << 48;
	localparam logic [63:0] INF_POS  = 64'h7FF0 << 48;
	localparam logic [63:0] INF_NEG  = 64'hFFF0 << 48;
	localparam logic [63:0] QNAN_POS = 64'h7FF1 << 48;
	localparam logic [63:0] ZERO_POS = 64'h3FF0 << 48;
	localparam logic [63:0] ZERO_NEG = 64'hBFF0 << 48;
	localparam logic [EXP_BITS-1:0] EXP_ALL_ONES = '1;

	// classified item handed from front to back
	typedef struct packed {
		logic        special;
		logic [63:0] special_word;
		logic        l_sign;
		logic        r_sign;
		logic        big_left;  // larger-exponent operand is the left one
		logic [12:0] big_exp;   // biased exponent of the larger operand
		logic [12:0] shift;     // exponent difference
		logic [63:0] big_coef;
		logic [63:0] small_coef;
	} dec64_item_t;

	function automatic logic [63:0] pow_ten(input logic [4:0] n);
		logic [63:0] p;
		case (n)
			5'd0:  p = 64'd1;
			5'd1:  p = 64'd10;
			5'd2:  p = 64'd100;
			5'd3:  p = 64'd1000;
			5'd4:  p = 64'd10000;
			5'd5:  p = 64'd100000;
			5'd6:  p = 64'd1000000;
			5'd7:  p = 64'd10000000;
			5'd8:  p = 64'd100000000;
			5'd9:  p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			5'd18: p = 64'd1000000000000000000;
			5'd19: p = 64'd10000000000000000000;
			default: p = '1;
		endcase
		return p;
	endfunction

endpackage

[rtl/core/dec64_front.sv]
module dec64_front (
	input  logic                  kind,
	input  logic [63:0]           left_word,
	input  logic [63:0]           right_word,
	output dec64_pkg::dec64_item_t item
);
	import dec64_pkg::*;

	logic [10:0] le, re;
	logic l_spec, r_spec, l_inf, r_inf, ls, rs;

	always_comb begin
		le = left_word[62:52];
		re = right_word[62:52];
		l_spec = (le == EXP_ALL_ONES);
		r_spec = (re == EXP_ALL_ONES);
		l_inf = l_spec && (left_word[51:48] == 4'd0);
		r_inf = r_spec && (right_word[51:48] == 4'd0);
		ls = left_word[63];
		rs = right_word[63] ^ kind;
		item = '0;
		item.special = l_spec || r_spec;
		if (l_spec && !l_inf) item.special_word = left_word;
		else if (r_spec && !r_inf) item.special_word = right_word;
		else if (l_inf) item.special_word = (r_inf && ls != rs) ? QNAN_POS : left_word;
		else item.special_word = kind ? (rs ? INF_NEG : INF_POS) : right_word;
		item.l_sign = ls;
		item.r_sign = rs;
		// order operands so that "big" has the larger exponent; signs stay by side
		if (le >= re) begin
			item.big_left = 1'b1;
			item.big_exp = {2'b0, le};
			item.shift = {2'b0, le - re};
			item.big_coef = {12'd0, left_word[51:0]};
			item.small_coef = {12'd0, right_word[51:0]};
		end else begin
			item.big_left = 1'b0;
			item.big_exp = {2'b0, re};
			item.shift = {2'b0, re - le};
			item.big_coef = {12'd0, right_word[51:0]};
			item.small_coef = {12'd0, left_word[51:0]};
		end
	end

endmodule

[rtl/core/dec64_back.sv]
module dec64_back #(
	parameter int EXP_BIAS    = 1023,
	parameter int DIGIT_LIMIT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  dec64_pkg::dec64_item_t item,
	output logic                  idle,
	output logic                  done,
	output logic [63:0]           result
);
	import dec64_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_COUNT = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_SUM   = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_NORM  = 7'b1000000
	} state_t;

	state_t state_q;
	dec64_item_t it_q;
	logic [63:0] big_q, small_q, res_q, est_q;
	logic [4:0]  nd_q, cnt_q;
	logic [12:0] over_q;
	logic        big_left_q, sign_q, half_q;
	logic signed [14:0] rexp_q;   // unbiased result exponent
	logic signed [14:0] rexp_b;
	logic [5:0]  cap;
	logic [63:0] diff;
	logic [63:0] div_in, div_est, div_fix;

	// divide by ten: shift-add estimate, then a one-step correction next cycle
	function automatic logic [63:0] div10_est(input logic [63:0] x);
		logic [63:0] q;
		q = (x >> 1) + (x >> 2);
		q = q + (q >> 4);
		q = q + (q >> 8);
		q = q + (q >> 16);
		q = q + (q >> 32);
		return q >> 3;
	endfunction

	function automatic logic [63:0] div10_fix(input logic [63:0] x, input logic [63:0] q);
		logic [63:0] r;
		r = x - ((q << 3) + (q << 1));
		return (r > 64'd9) ? q + 64'd1 : q;
	endfunction

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		cap = (6'(DIGIT_LIMIT + 1) < {1'b0, nd_q}) ? {1'b0, nd_q} : 6'(DIGIT_LIMIT + 1);
		diff = big_left_q ? big_q - small_q : small_q - big_q;
		rexp_b = rexp_q + 15'(EXP_BIAS);
		div_in = (state_q == ST_NORM) ? res_q : small_q;
		div_est = div10_est(div_in);
		div_fix = div10_fix(div_in, est_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			half_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						it_q <= item;
						big_q <= item.big_coef;
						small_q <= item.small_coef;
						nd_q <= '0;
						big_left_q <= item.big_left;
						rexp_q <= 15'(item.big_exp) - 15'(item.shift) - 15'(EXP_BIAS);
						if (item.special) begin
							result <= item.special_word;
							done <= 1'b1;
						end else begin
							state_q <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					// one digit per cycle
					if (big_q >= pow_ten(nd_q)) begin
						nd_q <= nd_q + 5'd1;
					end else begin
						if (nd_q == 5'd0 || it_q.shift == 13'd0) begin
							state_q <= ST_SUM;
						end else begin
							if (13'(nd_q) + it_q.shift <= 13'(cap)) begin
								cnt_q <= 5'(it_q.shift);
								over_q <= '0;
							end else begin
								cnt_q <= 5'(cap - {1'b0, nd_q});
								over_q <= 13'(nd_q) + it_q.shift - 13'(cap);
								rexp_q <= rexp_q + 15'(13'(nd_q) + it_q.shift - 13'(cap));
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					// scale up by ten once per cycle
					if (cnt_q != 5'd0) begin
						big_q <= (big_q << 3) + (big_q << 1);
						cnt_q <= cnt_q - 5'd1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (over_q >= 13'd20) begin
						small_q <= '0;
						state_q <= ST_SUM;
					end else if (over_q != 13'd0) begin
						if (!half_q) begin
							est_q <= div_est;
							half_q <= 1'b1;
						end else begin
							small_q <= div_fix;
							over_q <= over_q - 13'd1;
							half_q <= 1'b0;
						end
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (it_q.l_sign == it_q.r_sign) begin
						res_q <= big_q + small_q;
						sign_q <= it_q.l_sign;
					end else begin
						res_q <= diff;
						sign_q <= it_q.l_sign;
					end
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (it_q.l_sign && !it_q.r_sign && res_q == 64'd0) begin
						sign_q <= 1'b0;
					end else if (res_q[63]) begin
						res_q <= 64'd0 - res_q;
						sign_q <= ~sign_q;
					end
					rexp_q <= rexp_q;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (res_q > COEF_MAX) begin
						if (!half_q) begin
							est_q <= div_est;
							half_q <= 1'b1;
						end else begin
							res_q <= div_fix;
							rexp_q <= rexp_q + 15'sd1;
							half_q <= 1'b0;
						end
					end else begin
						if (rexp_b < 0) result <= sign_q ? ZERO_NEG : ZERO_POS;
						else if (rexp_b >= 15'sd2047) result <= sign_q ? INF_NEG : INF_POS;
						else result <= (sign_q ? SIGN_BIT : 64'd0)
							| (64'(rexp_b[10:0]) << COEF_BITS) | res_q;
						done <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/decimal64_add_subtract.sv]
// NaN/infinity operands skip the arithmetic; finite operands first count the
// coefficient digits; unequal exponents then add multiply-by-ten steps and one
// divide per truncated digit below twenty; renormalizing divides follow the sum.
// One item in the back unit and one waiting in the queue; one result per item.
// arst_n clears the control state; results cannot be stalled.
module decimal64_add_subtract #(
	parameter int EXP_BIAS    = 1023,
	parameter int DIGIT_LIMIT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] left_word,
	input  logic [63:0] right_word,
	output logic        strobe,
	output logic [63:0] sum_word
);
	import dec64_pkg::*;

	dec64_item_t fr_item, q_item;
	logic q_valid_q, back_idle;

	dec64_front u_front (.kind, .left_word, .right_word, .item(fr_item));

	assign busy = q_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q_valid_q <= 1'b0;
		else if (start && !busy) q_valid_q <= 1'b1;
		else if (back_idle) q_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) q_item <= fr_item;
	end

	dec64_back #(.EXP_BIAS(EXP_BIAS), .DIGIT_LIMIT(DIGIT_LIMIT)) u_back (
		.clk, .arst_n, .go(q_valid_q), .item(q_item), .idle(back_idle),
		.done(strobe), .result(sum_word));

endmodule

[rtl/core/dec64_checker.sv]
module dec64_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [63:0] sum_word
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({busy, strobe})) else $error("control outputs unknown");
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !$isunknown(sum_word)) else $error("sum_word unknown on strobe");
endmodule

bind decimal64_add_subtract dec64_checker u_chk (.clk, .arst_n, .start, .busy, .strobe,
	.sum_word);

[dv/tb_decimal64_add_subtract.sv]
module tb_decimal64_add_subtract;
	import dec64_pkg::*;

	localparam int BIAS = 1023;
	localparam int DLIM = 16;
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_SUB = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [63:0] left_word;
	logic [63:0] right_word;
	logic        strobe;
	logic [63:0] sum_word;

	int send_idle_pct;
	int n_ops;
	int n_special;

	decimal64_add_subtract #(.EXP_BIAS(BIAS), .DIGIT_LIMIT(DLIM)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.left_word(left_word), .right_word(right_word),
		.strobe(strobe), .sum_word(sum_word)
	);

	function automatic logic [63:0] ten_pow(int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) p = p * 64'd10;
		return p;
	endfunction

	function automatic int digits_of(logic [63:0] x);
		int n;
		n = 0;
		while (x != 0) begin
			x = x / 64'd10;
			n++;
		end
		return n;
	endfunction

	function automatic logic [63:0] pack_word(logic [63:0] v, int e, logic s);
		int r;
		r = e + BIAS;
		while (v > COEF_MAX) begin
			v = v / 64'd10;
			r++;
		end
		if (r < 0) return s ? ZERO_NEG : ZERO_POS;
		if (r >= 2047) return s ? INF_NEG : INF_POS;
		return (s ? SIGN_BIT : 64'd0) | (64'(r) << COEF_BITS) | v;
	endfunction

	function automatic logic is_spec(logic [63:0] w);
		return w[62:52] == EXP_ALL_ONES;
	endfunction

	function automatic logic is_infw(logic [63:0] w);
		return is_spec(w) && w[51:48] == 4'd0;
	endfunction

	// scale the larger-exponent coefficient, truncate the other on overflow
	function automatic void line_up(inout logic [63:0] big, inout logic [63:0] sml,
		input int shift, inout int rexp);
		int nd, cap, over;
		nd = digits_of(big);
		cap = DLIM + 1;
		if (nd == 0) return;
		if (cap < nd) cap = nd;
		over = nd + shift - cap;
		if (over <= 0) begin
			big = big * ten_pow(shift);
		end else begin
			big = big * ten_pow(cap - nd);
			sml = (over >= 20) ? 64'd0 : sml / ten_pow(over);
			rexp += over;
		end
	endfunction

	function automatic logic [63:0] predict_sum(logic k, logic [63:0] lw, logic [63:0] rw);
		logic ls, rs;
		int le, re, rexp;
		logic [63:0] lc, rc, res;
		ls = lw[63];
		rs = rw[63] ^ k;
		if (is_spec(lw) || is_spec(rw)) begin
			if (is_spec(lw) && !is_infw(lw)) return lw;
			if (is_spec(rw) && !is_infw(rw)) return rw;
			if (is_infw(lw)) return (is_infw(rw) && ls != rs) ? QNAN_POS : lw;
			return k ? (rs ? INF_NEG : INF_POS) : rw;
		end
		le = int'(lw[62:52]) - BIAS;
		re = int'(rw[62:52]) - BIAS;
		lc = lw & COEF_MAX;
		rc = rw & COEF_MAX;
		rexp = (le < re) ? le : re;
		if (le > re) line_up(lc, rc, le - re, rexp);
		else if (re > le) line_up(rc, lc, re - le, rexp);
		res = (ls == rs) ? lc + rc : lc - rc;
		if (ls && !rs && res == 0) return pack_word(64'd0, rexp, 1'b0);
		if (res[63] == 1'b0) return pack_word(res, rexp, ls);
		return pack_word(64'd0 - res, rexp, ~ls);
	endfunction

	class SumScoreboard;
		logic [63:0] pending_sums[$];
		int errors;

		function void note_op(logic k, logic [63:0] lw, logic [63:0] rw);
			pending_sums.push_back(predict_sum(k, lw, rw));
		endfunction

		function void check_sum(logic [63:0] got);
			logic [63:0] want;
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_sums.pop_front();
			if (want !== got) begin
				$display("%0t: sum_word mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	SumScoreboard sb;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_op(kind, left_word, right_word);
		if (arst_n && strobe) sb.check_sum(sum_word);
	end

	function automatic logic [63:0] mk(logic s, int e, logic [63:0] c);
		return {s, 11'(e), c[51:0]};
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] c;
		int e;
		int pick;
		pick = $urandom_range(0, 19);
		e = (pick < 14) ? BIAS + $urandom_range(0, 40) - 20 : $urandom_range(0, 2047);
		case ($urandom_range(0, 3))
			0: c = 64'($urandom_range(0, 999));
			1: c = {$urandom, $urandom} & COEF_MAX;
			2: c = 64'($urandom) % ten_pow($urandom_range(1, 16));
			default: c = 64'($urandom);
		endcase
		if (pick == 19) return {$urandom, $urandom};
		if (pick == 18) return {1'($urandom), EXP_ALL_ONES, 52'({$urandom, $urandom}) >> $urandom_range(0, 52)};
		return mk(1'($urandom), e, c);
	endfunction

	task automatic send_op(logic k, logic [63:0] lw, logic [63:0] rw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		left_word <= lw;
		right_word <= rw;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		n_ops++;
		if (is_spec(lw) || is_spec(rw)) n_special++;
	endtask

	initial begin
		logic [63:0] dl[$];
		sb = new();
		start = 1'b0;
		kind = KIND_ADD;
		left_word = '0;
		right_word = '0;
		arst_n = 1'b0;
		send_idle_pct = 15;
		n_ops = 0;
		n_special = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		dl = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, INF_POS, INF_NEG, QNAN_POS,
			64'hFFF8_0000_0000_0001, mk(0, BIAS, COEF_MAX), mk(1, BIAS, 64'd5),
			mk(0, 2046, COEF_MAX), mk(1, 0, 64'd1), mk(0, BIAS + 30, 64'd7),
			mk(1, BIAS, 64'd0), mk(0, BIAS - 25, COEF_MAX)};
		foreach (dl[i]) send_op(i[0] ? KIND_SUB : KIND_ADD, dl[i], dl[(i * 5 + 3) % dl.size()]);
		send_op(KIND_SUB, mk(0, BIAS, 64'd5), mk(0, BIAS, 64'd5));
		send_op(KIND_ADD, mk(1, BIAS, 64'd5), mk(0, BIAS, 64'd5));
		send_op(KIND_SUB, INF_POS, INF_POS);
		send_op(KIND_ADD, INF_POS, INF_NEG);
		send_op(KIND_SUB, mk(0, BIAS, 64'd3), INF_POS);
		send_op(KIND_ADD, mk(0, BIAS, 64'd3), INF_NEG);
		send_op(KIND_SUB, mk(0, BIAS, 64'd3), 64'hFFF1_0000_0000_0000);
		send_op(KIND_ADD, mk(0, BIAS + 5, 64'd0), mk(0, BIAS, 64'd12));
		send_op(KIND_ADD, mk(0, BIAS + 40, 64'd9), mk(0, BIAS, 64'd12));
		send_op(KIND_SUB, mk(0, 2046, COEF_MAX), mk(1, 2046, COEF_MAX));
		send_op(KIND_SUB, mk(0, 0, 64'd1), mk(0, 0, 64'd2));

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 51 : 0;
			repeat (200) send_op(1'($urandom), rand_word(), rand_word());
		end
		start <= 1'b0;

		while (sb.pending_sums.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Covered %0d add/subtract transfers, %0d with NaN or infinity operands.",
			n_ops, n_special);
		if (sb.errors == 0 && sb.pending_sums.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
